>>> design/idsp_pkg.sv
// shared types and constants for the streaming timestamp parser
// no dependencies; imported by every module of the block

package idsp_pkg;

	// parse phases of the back end
	typedef enum logic [3:0] {
		PH_YEAR = 4'd0,
		PH_MON  = 4'd1,
		PH_DAY  = 4'd2,
		PH_HOUR = 4'd3,
		PH_MIN  = 4'd4,
		PH_SEC  = 4'd5,
		PH_FRAC = 4'd6,
		PH_ZHR  = 4'd7,
		PH_ZMIN = 4'd8,
		PH_DONE = 4'd9
	} phase_t;

	// character classes found by the front end
	typedef enum logic [3:0] {
		CK_DIGIT,
		CK_TERM,
		CK_DASH,
		CK_TSEP,
		CK_COLON,
		CK_DOT,
		CK_ZULU,
		CK_PLUS,
		CK_OTHER
	} char_kind_t;

	// one classified item as it travels through the queue
	typedef struct packed {
		char_kind_t kind;
		logic [3:0] digit;
	} char_item_t;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_DASH  = 8'h2D;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_DOT   = 8'h2E;
	localparam logic [7:0] CHR_COLON = 8'h3A;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_T     = 8'h54;
	localparam logic [7:0] CHR_Z     = 8'h5A;

	localparam int unsigned YEAR_LIMIT  = 9999;
	localparam int unsigned FIELD_LIMIT = 99;
	localparam int unsigned YEAR_BASE   = 1900;
	localparam int unsigned SEC_PER_HR  = 3600;
	localparam int unsigned SEC_PER_MIN = 60;

	localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> design/idsp_front.sv
// front end: takes text bytes and classifies them into queue items
// depends on idsp_pkg

module idsp_front
	import idsp_pkg::*;
(
	input  logic [7:0]  char_code,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        q_full,
	output logic        q_push,
	output char_item_t  q_item
);

	logic [7:0] digit_off;

	// handshake: accept whenever the queue has room
	assign in_ready  = !q_full;
	assign q_push    = in_valid && !q_full;
	assign digit_off = char_code - CHR_ZERO;

	// character classifier
	always_comb begin
		q_item.digit = digit_off[3:0];
		if (char_code >= CHR_ZERO && char_code <= CHR_NINE) begin
			q_item.kind = CK_DIGIT;
		end else begin
			case (char_code)
				CHR_NUL:   q_item.kind = CK_TERM;
				CHR_DASH:  q_item.kind = CK_DASH;
				CHR_T:     q_item.kind = CK_TSEP;
				CHR_COLON: q_item.kind = CK_COLON;
				CHR_DOT:   q_item.kind = CK_DOT;
				CHR_Z:     q_item.kind = CK_ZULU;
				CHR_PLUS:  q_item.kind = CK_PLUS;
				default:   q_item.kind = CK_OTHER;
			endcase
		end
	end

endmodule

>>> design/idsp_queue.sv
// two-entry item queue between the front and back ends
// depends on idsp_pkg

module idsp_queue
	import idsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_item_t  push_item,
	output logic        full,
	input  logic        pop,
	output logic        q_valid,
	output char_item_t  q_item
);

	char_item_t entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'(QUEUE_DEPTH));
	assign q_valid = (count_q != 2'd0);
	assign q_item  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> design/idsp_back.sv
// back end: field parser state machine and result register
// depends on idsp_pkg

module idsp_back
	import idsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  char_item_t         q_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [13:0] year_since_1900,
	output logic signed [7:0]  month_index,
	output logic [6:0]         day_of_month,
	output logic [6:0]         hour_value,
	output logic [6:0]         minute_value,
	output logic [6:0]         second_value,
	output logic signed [19:0] zone_offset_seconds,
	output logic               zone_known
);

	// parse state
	phase_t      phase_q, phase_d;
	logic [13:0] acc_q, acc_d;
	logic [13:0] year_q, year_d;
	logic [6:0]  month_q, month_d;
	logic [6:0]  day_q, day_d;
	logic [6:0]  hour_q, hour_d;
	logic [6:0]  minute_q, minute_d;
	logic [6:0]  second_q, second_d;
	logic        neg_q, neg_d;
	logic [6:0]  zhour_q, zhour_d;
	logic        zset_q, zset_d;
	logic        err_q, err_d;
	logic        out_valid_q;

	// result values formed at the terminator
	logic        is_term;
	logic        load_out;
	logic        bad;
	logic [6:0]  sec_fin;
	logic [6:0]  zh_fin;
	logic [6:0]  zm_fin;
	logic [18:0] off_mag;
	logic [19:0] off_val;
	logic        is_digit;
	logic [13:0] acc_year;
	logic [13:0] acc_field;

	// decimal accumulate with saturation
	function automatic logic [13:0] acc_step(input logic [13:0] acc, input logic [3:0] dig,
		input logic [13:0] limit);
		logic [16:0] v;
		v = 17'(acc) * 17'd10 + 17'(dig);
		if (v > 17'(limit)) return limit;
		return v[13:0];
	endfunction

	assign is_term   = (q_item.kind == CK_TERM);
	assign is_digit  = (q_item.kind == CK_DIGIT);
	assign pop       = q_valid && (!is_term || !out_valid_q || out_ready);
	assign load_out  = pop && is_term;
	assign out_valid = out_valid_q;
	assign acc_year  = acc_step(acc_q, q_item.digit, 14'(YEAR_LIMIT));
	assign acc_field = acc_step(acc_q, q_item.digit, 14'(FIELD_LIMIT));

	// final field values and zone offset
	always_comb begin
		bad     = err_q || (phase_q < PH_SEC) || (phase_q > PH_DONE);
		sec_fin = (phase_q == PH_SEC) ? acc_q[6:0] : second_q;
		zh_fin  = (phase_q == PH_ZHR) ? acc_q[6:0] : zhour_q;
		zm_fin  = (phase_q == PH_ZMIN || phase_q == PH_DONE) ? acc_q[6:0] : 7'd0;
		off_mag = 19'(zh_fin) * 19'(SEC_PER_HR) + 19'(zm_fin) * 19'(SEC_PER_MIN);
		off_val = neg_q ? (20'd0 - {1'b0, off_mag}) : {1'b0, off_mag};
	end

	// next parse state
	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		neg_d    = neg_q;
		zhour_d  = zhour_q;
		zset_d   = zset_q;
		err_d    = err_q;
		if (pop && is_term) begin
			// terminator returns the parser to its reset state
			phase_d  = PH_YEAR;
			acc_d    = '0;
			year_d   = '0;
			month_d  = '0;
			day_d    = '0;
			hour_d   = '0;
			minute_d = '0;
			second_d = '0;
			neg_d    = 1'b0;
			zhour_d  = '0;
			zset_d   = 1'b0;
			err_d    = 1'b0;
		end else if (pop && !err_q) begin
			unique case (phase_q)
				PH_YEAR: begin
					if (is_digit) acc_d = acc_year;
					else if (q_item.kind == CK_DASH) begin
						year_d  = acc_q;
						acc_d   = '0;
						phase_d = PH_MON;
					end else err_d = 1'b1;
				end
				PH_MON: begin
					if (is_digit) acc_d = acc_field;
					else if (q_item.kind == CK_DASH) begin
						month_d = acc_q[6:0];
						acc_d   = '0;
						phase_d = PH_DAY;
					end else err_d = 1'b1;
				end
				PH_DAY: begin
					if (is_digit) acc_d = acc_field;
					else if (q_item.kind == CK_TSEP) begin
						day_d   = acc_q[6:0];
						acc_d   = '0;
						phase_d = PH_HOUR;
					end else err_d = 1'b1;
				end
				PH_HOUR: begin
					if (is_digit) acc_d = acc_field;
					else if (q_item.kind == CK_COLON) begin
						hour_d  = acc_q[6:0];
						acc_d   = '0;
						phase_d = PH_MIN;
					end else err_d = 1'b1;
				end
				PH_MIN: begin
					if (is_digit) acc_d = acc_field;
					else if (q_item.kind == CK_COLON) begin
						minute_d = acc_q[6:0];
						acc_d    = '0;
						phase_d  = PH_SEC;
					end else err_d = 1'b1;
				end
				PH_SEC, PH_FRAC: begin
					if (is_digit) begin
						if (phase_q == PH_SEC) acc_d = acc_field;
					end else begin
						if (phase_q == PH_SEC) begin
							second_d = acc_q[6:0];
							acc_d    = '0;
						end
						// zone or fraction start
						case (q_item.kind)
							CK_DOT: begin
								if (phase_q == PH_SEC) phase_d = PH_FRAC;
								else err_d = 1'b1;
							end
							CK_ZULU: begin
								zset_d  = 1'b1;
								phase_d = PH_DONE;
							end
							CK_PLUS, CK_DASH: begin
								zset_d  = 1'b1;
								neg_d   = (q_item.kind == CK_DASH);
								phase_d = PH_ZHR;
							end
							default: err_d = 1'b1;
						endcase
					end
				end
				PH_ZHR: begin
					if (is_digit) acc_d = acc_field;
					else begin
						zhour_d = acc_q[6:0];
						acc_d   = '0;
						phase_d = (q_item.kind == CK_COLON) ? PH_ZMIN : PH_DONE;
					end
				end
				PH_ZMIN: begin
					if (is_digit) acc_d = acc_field;
					else phase_d = PH_DONE;
				end
				PH_DONE: begin
				end
				default: err_d = 1'b1;
			endcase
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_YEAR;
			acc_q       <= '0;
			year_q      <= '0;
			month_q     <= '0;
			day_q       <= '0;
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			neg_q       <= 1'b0;
			zhour_q     <= '0;
			zset_q      <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			year_q   <= year_d;
			month_q  <= month_d;
			day_q    <= day_d;
			hour_q   <= hour_d;
			minute_q <= minute_d;
			second_q <= second_d;
			neg_q    <= neg_d;
			zhour_q  <= zhour_d;
			zset_q   <= zset_d;
			err_q    <= err_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// result register, all value fields zero and status set on a malformed timestamp
	always_ff @(posedge clk) begin
		if (load_out) begin
			status              <= bad;
			year_since_1900     <= bad ? '0 : signed'(year_q - 14'(YEAR_BASE));
			month_index         <= bad ? '0 : signed'({1'b0, month_q} - 8'd1);
			day_of_month        <= bad ? '0 : day_q;
			hour_value          <= bad ? '0 : hour_q;
			minute_value        <= bad ? '0 : minute_q;
			second_value        <= bad ? '0 : sec_fin;
			zone_offset_seconds <= bad ? '0 : signed'(off_val);
			zone_known          <= bad ? 1'b0 : zset_q;
		end
	end

endmodule

>>> design/iso_datetime_stream_parser_core.sv
// top level of the streaming ISO 8601 timestamp parser
// depends on idsp_pkg, idsp_front, idsp_queue, idsp_back
//
//   channel   handshake              payload
//   input     in_valid / in_ready    char_code
//   output    out_valid / out_ready  status, year_since_1900, month_index,
//                                    day_of_month, hour_value, minute_value,
//                                    second_value, zone_offset_seconds, zone_known
//
// one item per cycle sustained unless a held result stalls a terminator; a terminator's
// result is presented after the item passes through the queue and loads the result register
// the parser handles one character per cycle, unless a held result stalls a terminator,
// with one multiply-add by ten; arst_n clears the queue, the parse phase and all parse field registers
// a held result stalls only a terminator at the queue head; characters ahead of it keep
// moving, and in_ready drops only when both queue entries are full

module iso_datetime_stream_parser_core
	import idsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [13:0] year_since_1900,
	output logic signed [7:0]  month_index,
	output logic [6:0]         day_of_month,
	output logic [6:0]         hour_value,
	output logic [6:0]         minute_value,
	output logic [6:0]         second_value,
	output logic signed [19:0] zone_offset_seconds,
	output logic               zone_known
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_valid;
	char_item_t push_item;
	char_item_t head_item;

	// classifier
	idsp_front u_front (
		.char_code (char_code),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// decoupling queue
	idsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_item    (head_item)
	);

	// parser and result register
	idsp_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.q_valid             (q_valid),
		.q_item              (head_item),
		.pop                 (q_pop),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.status              (status),
		.year_since_1900     (year_since_1900),
		.month_index         (month_index),
		.day_of_month        (day_of_month),
		.hour_value          (hour_value),
		.minute_value        (minute_value),
		.second_value        (second_value),
		.zone_offset_seconds (zone_offset_seconds),
		.zone_known          (zone_known)
	);

endmodule
